/* rtl/core/bmb_pkg.sv */
// ----------------------------------------------------------------------------
// bmb_pkg
// Shared constants and types for the band meter with peak hold.
// ----------------------------------------------------------------------------
package bmb_pkg;

    localparam int NUM_BANDS  = 7;
    localparam int BAND_W     = 3;
    localparam int BAND_IDX_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
    localparam int LEVEL_W    = 16;
    localparam int COEFF_W    = 16;
    localparam int HOLD_W     = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 40;

    localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 8'd3;

    localparam logic [COEFF_W-1:0] ATTACK_RESET  = 16'd16384;
    localparam logic [COEFF_W-1:0] RELEASE_RESET = 16'd3277;
    localparam logic [HOLD_W-1:0]  HOLD_RESET    = 8'd30;
    localparam logic [COEFF_W-1:0] DECAY_RESET   = 16'd31130;

    typedef struct packed {
        logic [COEFF_W-1:0] attack_coeff;
        logic [COEFF_W-1:0] release_coeff;
        logic [HOLD_W-1:0]  hold_frames;
        logic [COEFF_W-1:0] peak_decay;
    } t_cfg;

    // Stored state of one band.
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] peak;
        logic [HOLD_W-1:0]  hold;
    } t_band_state;

endpackage

/* rtl/core/bmb_cfg_regs.sv */
// ----------------------------------------------------------------------------
// bmb_cfg_regs
// Configuration register file: ballistics coefficients, hold time and decay.
// ----------------------------------------------------------------------------
module bmb_cfg_regs
    import bmb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_wr_index,
    input  logic [CFG_DATA_W-1:0] i_wr_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack_coeff  <= ATTACK_RESET;
            r_cfg.release_coeff <= RELEASE_RESET;
            r_cfg.hold_frames   <= HOLD_RESET;
            r_cfg.peak_decay    <= DECAY_RESET;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                REG_ATTACK:  r_cfg.attack_coeff  <= i_wr_data;
                REG_RELEASE: r_cfg.release_coeff <= i_wr_data;
                REG_HOLD:    r_cfg.hold_frames   <= i_wr_data[HOLD_W-1:0];
                REG_DECAY:   r_cfg.peak_decay    <= i_wr_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/core/bmb_band_calc.sv */
// ----------------------------------------------------------------------------
// bmb_band_calc
// Ballistics and peak-hold update for one band, purely combinational.
// ----------------------------------------------------------------------------
module bmb_band_calc
    import bmb_pkg::*;
(
    input  t_cfg               i_cfg,
    input  logic [LEVEL_W-1:0] i_target,
    input  t_band_state        i_state,
    output t_band_state        o_state
);

    logic                      attack;
    logic signed [LEVEL_W:0]   diff;
    logic signed [COEFF_W:0]   alpha;
    logic signed [LEVEL_W+COEFF_W+1:0] prod;
    logic signed [LEVEL_W+2:0] step;
    logic signed [LEVEL_W+2:0] sum;
    logic [LEVEL_W-1:0]        lvl;
    logic [LEVEL_W+COEFF_W-1:0] dprod;
    logic [LEVEL_W+COEFF_W-16:0] decayed;
    logic [LEVEL_W-1:0]        dsat;

    always_comb begin
        attack = i_target > i_state.level;
        diff   = $signed({1'b0, i_target}) - $signed({1'b0, i_state.level});
        alpha  = $signed({1'b0, attack ? i_cfg.attack_coeff : i_cfg.release_coeff});
        prod   = (LEVEL_W+COEFF_W+2)'(diff) * (LEVEL_W+COEFF_W+2)'(alpha);
        // Arithmetic shift rounds the step towards minus infinity; the sign bit
        // of the product is carried into the step.
        step   = prod[LEVEL_W+COEFF_W+1:15];
        sum    = $signed({3'b000, i_state.level}) + step;
        if (sum < 0) begin
            lvl = '0;
        end else if (sum > $signed({3'b000, {LEVEL_W{1'b1}}})) begin
            lvl = '1;
        end else begin
            lvl = sum[LEVEL_W-1:0];
        end

        // The decay product depends on the stored peak and the decay coefficient only.
        dprod   = i_state.peak * i_cfg.peak_decay;
        decayed = dprod[LEVEL_W+COEFF_W-1:15];
        dsat    = decayed[LEVEL_W+COEFF_W-16] ? '1 : decayed[LEVEL_W-1:0];

        o_state.level = lvl;
        if (lvl >= i_state.peak) begin
            o_state.peak = lvl;
            o_state.hold = i_cfg.hold_frames;
        end else if (i_state.hold != '0) begin
            o_state.peak = i_state.peak;
            o_state.hold = i_state.hold - HOLD_W'(1);
        end else begin
            o_state.peak = dsat;
            o_state.hold = i_state.hold;
        end
    end

endmodule

/* rtl/core/band_meter_ballistics_peak_hold_core.sv */
// ----------------------------------------------------------------------------
// band_meter_ballistics_peak_hold_core
// Per-band level meter with attack/release smoothing and peak hold.
// ----------------------------------------------------------------------------
// Each input beat names a band and its target energy (unsigned Q1.15). The
// beat is registered, the band's level, peak and hold counter are read from
// flip-flop stores, updated in one pass of logic and written back at the same
// edge that loads the result register, so one beat per clock is taken while
// the output is not stalled, and each result leaves from the result register
// after its beat has passed the input register. A beat for a band index at
// or above seven changes nothing and yields no result. Back-pressure on the
// output holds the input register; the next input beat is still taken while
// that register is free. All stores clear to zero at reset; configuration
// writes are taken in any cycle but are meant for an idle block.
module band_meter_ballistics_peak_hold_core
    import bmb_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [2:0] band, [18:3] band_energy, [23:19] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [2:0] band_out, [18:3] display_level, [34:19] peak_level, [39:35] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg               cfg;
    logic               r_in_valid;
    logic [BAND_W-1:0]  r_in_band;
    logic [LEVEL_W-1:0] r_in_energy;
    logic               r_out_valid;
    logic [BAND_W-1:0]  r_out_band;
    logic [LEVEL_W-1:0] r_out_level;
    logic [LEVEL_W-1:0] r_out_peak;
    t_band_state        r_store [NUM_BANDS];
    t_band_state        cur_state;
    t_band_state        n_state;
    logic               in_range;
    logic               advance;

    assign o_cfg_ready = 1'b1;

    bmb_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    assign in_range  = r_in_band < BAND_W'(NUM_BANDS);
    assign cur_state = in_range ? r_store[r_in_band[BAND_IDX_W-1:0]] : '0;

    bmb_band_calc u_calc (
        .i_cfg    (cfg),
        .i_target (r_in_energy),
        .i_state  (cur_state),
        .o_state  (n_state)
    );

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready) begin
            r_in_band   <= s_axis_tdata[BAND_W-1:0];
            r_in_energy <= s_axis_tdata[BAND_W+LEVEL_W-1:BAND_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && in_range;
        end
        if (advance) begin
            r_out_band  <= r_in_band;
            r_out_level <= n_state.level;
            r_out_peak  <= n_state.peak;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BANDS; i++) begin
                r_store[i] <= '0;
            end
        end else if (advance && r_in_valid && in_range) begin
            r_store[r_in_band[BAND_IDX_W-1:0]] <= n_state;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b00000, r_out_peak, r_out_level, r_out_band};

    // A result on the port never names a band outside the stores.
    a_out_band_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_out_band < BAND_W'(NUM_BANDS)))
        else $error("result carries an out-of-range band");

    // A waiting result always matches what its band's store now holds.
    a_out_matches_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (r_store[r_out_band[BAND_IDX_W-1:0]].level == r_out_level &&
             r_store[r_out_band[BAND_IDX_W-1:0]].peak == r_out_peak))
        else $error("result differs from its band store");

    // A stalled result keeps the input register from moving on.
    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready && r_in_valid) |-> !s_axis_tready)
        else $error("input taken while the pipeline is stalled");

endmodule
